/* sv/sha1md_pkg.sv */
package sha1md_pkg;

    // one message item: an optional byte and an end-of-message flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } msg_item_t;

    // one digest word with its position
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    localparam int unsigned HASH_WORDS = 5;
    localparam int unsigned ROUNDS     = 80;

    localparam logic [31:0] SHA1_IV [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] SHA1_K0 = 32'h5A827999;
    localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] BEFORE_LEN = 6'd55;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_INDEX = 3'd4;

endpackage

/* sv/sha1_message_digest.sv */
// SHA-1 digest engine, one message byte per msg transaction.
//
// msg channel: each transaction carries data_byte (used when byte_present
// is set) and message_end. An empty message is one transaction with no
// byte and the end flag set. msg_stall is low only while the engine idles.
// digest channel: after the end flag the engine delivers five transactions,
// h0..h4 in order with word_index 0..4, last_word set on the fifth.
//
// timing: a byte that does not complete a block is simply stored. The 64th
// byte of a block starts the compression, one round per cycle through a
// single round adder, followed by the chaining add.
// At the end flag the padding bytes are fed one per cycle (between 9 and
// 72 bytes, paused while a full block compresses), with one or two
// compressions in all, then the five digest words, one per cycle unless
// the receiver stalls. A stalled digest word holds still until taken.
// After the fifth word the engine returns to its initial chaining value and takes the next message.
// reset: asynchronous, active low, leaves the engine idle with the initial
// chaining value and an empty block.
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    output logic         msg_stall,
    input  msg_item_t    msg,
    output logic         digest_valid,
    input  logic         digest_stall,
    output digest_item_t digest
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_FINAL = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

    state_t       state_reg, state_next;
    logic [31:0]  chain_reg [HASH_WORDS];
    logic [31:0]  chain_next [HASH_WORDS];
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  len_reg, len_next;
    logic         pad_reg, pad_next;        // message ended, padding under way
    logic         mark_reg, mark_next;      // 0x80 already appended
    logic         lenph_reg, lenph_next;    // now appending the bit length
    logic [6:0]   round_reg, round_next;
    logic [2:0]   idx_reg, idx_next;
    // 16-word schedule window, word 0 in the top bits; bytes shift in here too
    logic [511:0] win_reg, win_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;

    logic         push;
    logic [7:0]   push_byte;
    logic [63:0]  bit_len;
    logic [2:0]   len_sel;
    logic [31:0]  w_cur, w_new, f_val, k_val, tmp;

    assign msg_stall    = (state_reg != ST_IDLE);
    assign digest_valid = (state_reg == ST_OUT);
    assign digest.digest_word = chain_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == LAST_INDEX);

    assign bit_len = {len_reg[60:0], 3'b000};
    assign len_sel = fill_reg[2:0];     // fill 56..63 selects length byte 0..7

    // round function, one round per cycle
    assign w_cur = win_reg[511 -: 32];
    assign w_new = rotl(win_reg[511-32*13 -: 32] ^ win_reg[511-32*8 -: 32]
                      ^ win_reg[511-32*2 -: 32] ^ w_cur, 1);

    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = SHA1_K0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = SHA1_K1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = SHA1_K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = SHA1_K3;
        end
    end

    assign tmp = rotl(a_reg, 5) + f_val + e_reg + k_val + w_cur;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        chain_next = chain_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        lenph_next = lenph_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        win_next   = win_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        push       = 1'b0;
        push_byte  = msg.data_byte;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    push = msg.byte_present;
                    if (msg.byte_present)
                        len_next = len_reg + 64'd1;
                    if (msg.message_end)
                    begin
                        pad_next   = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push = 1'b1;
                if (!mark_reg)
                begin
                    push_byte = PAD_MARK;
                    mark_next = 1'b1;
                end
                else if (lenph_reg)
                    push_byte = bit_len[63 - 8*int'(len_sel) -: 8];
                else
                    push_byte = 8'h00;
                // the next byte lands at the length offset
                if (fill_reg == BEFORE_LEN)
                    lenph_next = 1'b1;
            end
            ST_ROUND:
            begin
                a_next     = tmp;
                b_next     = a_reg;
                c_next     = rotl(b_reg, 30);
                d_next     = c_reg;
                e_next     = d_reg;
                win_next   = {win_reg[479:0], w_new};
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                if (lenph_reg)
                    state_next = ST_OUT;
                else if (pad_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (!digest_stall)
                begin
                    if (idx_reg == LAST_INDEX)
                    begin
                        chain_next = SHA1_IV;
                        fill_next  = '0;
                        len_next   = '0;
                        pad_next   = 1'b0;
                        mark_next  = 1'b0;
                        lenph_next = 1'b0;
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // byte into the block; a full block starts the compression
        if (push)
        begin
            win_next  = {win_reg[503:0], push_byte};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == LAST_BYTE)
            begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                e_next     = chain_reg[4];
                round_next = '0;
                state_next = ST_ROUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chain_reg <= SHA1_IV;
            fill_reg  <= '0;
            len_reg   <= '0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            lenph_reg <= 1'b0;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            lenph_reg <= lenph_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

endmodule

/* sv/sha1md_check.sv */
module sha1md_check
    import sha1md_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         msg_valid,
    input logic         msg_stall,
    input msg_item_t    msg,
    input logic         digest_valid,
    input logic         digest_stall,
    input digest_item_t digest
);

    // never takes a message byte while a digest is being delivered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> msg_stall)
        else $error("message accepted during digest delivery");

    // words follow one another in index order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && !digest.last_word) |=>
        (digest_valid && digest.word_index == 3'($past(digest.word_index) + 3'd1)))
        else $error("digest word index out of sequence");

    // last word flag marks index four only
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_word == (digest.word_index == LAST_INDEX)))
        else $error("last_word does not match word_index");

    // after the last word the engine is ready for a new message
    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && digest.last_word) |=>
        (!digest_valid && !msg_stall))
        else $error("engine not idle after digest");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_stall) |=> (digest_valid && $stable(digest)))
        else $error("stalled digest transaction changed");

endmodule

bind sha1_message_digest sha1md_check u_sha1md_check (.*);

/* tb/sha1_message_digest_test.sv */
module sha1_message_digest_test;
    import sha1md_pkg::*;

    // run length guard, far above the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 300000;
    // quiet time after the last digest word: padding plus two compressions
    localparam int unsigned SETTLE_CYCLES = 400;
    // message lengths around the padding and block boundaries
    localparam int unsigned BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         msg_valid = 1'b0;
    logic         msg_stall;
    msg_item_t    msg = '0;
    logic         digest_valid;
    logic         digest_stall = 1'b0;
    digest_item_t digest;

    sha1_message_digest u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    always #5 clk = ~clk;

    // message transactions waiting to be driven, filled by the stimulus block
    msg_item_t    msg_backlog [$];
    // digest words the hash of each closed message should produce, oldest first
    digest_item_t digest_due [$];

    // idle rates in percent, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned items_queued = 0;
    int unsigned msgs_queued = 0;
    int unsigned items_taken = 0;
    int unsigned msgs_hashed = 0;
    int unsigned words_checked = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // running hash state: chaining value, partial block, byte count
    logic [31:0] chain [HASH_WORDS];
    logic [7:0]  block_bytes [64];
    int unsigned block_fill = 0;
    logic [63:0] byte_total = '0;

    initial
    begin
        for (int i = 0; i < HASH_WORDS; i++)
            chain[i] = SHA1_IV[i];
    end

    function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // 80-round compression of the full block into the chaining value
    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < ROUNDS; r++)
        begin
            // schedule expansion reuses a 16-word window
            if (r >= 16)
                w[r % 16] = rol(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16]
                                ^ w[r % 16], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = SHA1_K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = SHA1_K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = SHA1_K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = SHA1_K3;
            end
            t = rol(a, 5) + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        block_bytes[block_fill] = v;
        block_fill++;
        if (block_fill == 64)
        begin
            compress_block();
            block_fill = 0;
        end
    endfunction

    // advance the hash by one accepted message transaction; on the end flag
    // pad, finish and queue the five digest words, then start a fresh message
    function automatic void hash_item(input msg_item_t m);
        logic [63:0]  bit_len;
        digest_item_t word;
        if (m.byte_present)
        begin
            byte_total++;
            absorb_byte(m.data_byte);
        end
        if (!m.message_end)
            return;
        bit_len = byte_total << 3;
        absorb_byte(PAD_MARK);
        while (block_fill != 56)
            absorb_byte(8'h00);
        for (int i = 0; i < 8; i++)
            absorb_byte(bit_len[63 - 8*i -: 8]);
        for (int i = 0; i < HASH_WORDS; i++)
        begin
            word.digest_word = chain[i];
            word.word_index  = 3'(i);
            word.last_word   = (3'(i) == LAST_INDEX);
            digest_due.insert(digest_due.size(), word);
        end
        for (int i = 0; i < HASH_WORDS; i++)
            chain[i] = SHA1_IV[i];
        block_fill = 0;
        byte_total = '0;
        msgs_hashed++;
    endfunction

    // driver: a raised valid holds its payload until taken, then the next
    // transaction goes out unless this cycle idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            msg       <= '0;
        end
        else
        begin
            if (msg_valid && !msg_stall)
            begin
                hash_item(msg);
                items_taken++;
            end
            if (msg_valid && msg_stall)
            begin
                // stalled: keep valid and payload as they are
            end
            else if (msg_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                msg_valid <= 1'b1;
                msg       <= msg_backlog.pop_front();
            end
            else
                msg_valid <= 1'b0;
        end
    end

    // receiver stall, drawn fresh every cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digest_stall <= 1'b0;
        else
            digest_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // monitor: every digest transaction against the oldest word due
    always @(posedge clk)
    begin
        digest_item_t want;
        if (rst_n && digest_valid && !digest_stall)
        begin
            if (digest_due.size() == 0)
            begin
                $error("digest word %h arrived with no word due", digest.digest_word);
                fail_count++;
            end
            else
            begin
                want = digest_due.pop_front();
                words_checked++;
                if (digest.digest_word !== want.digest_word)
                begin
                    $error("digest_word: expected %h, got %h",
                           want.digest_word, digest.digest_word);
                    fail_count++;
                end
                if (digest.word_index !== want.word_index)
                begin
                    $error("word_index: expected %0d, got %0d",
                           want.word_index, digest.word_index);
                    fail_count++;
                end
                if (digest.last_word !== want.last_word)
                begin
                    $error("last_word: expected %0b, got %0b",
                           want.last_word, digest.last_word);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digest words still due",
                     cycle_count, digest_due.size());
            $display("sha1_message_digest verification failed");
            $finish;
        end
    end

    function automatic void push_item(input logic [7:0] dbyte, input logic present,
                                      input logic closes);
        msg_item_t m;
        m.data_byte    = dbyte;
        m.byte_present = present;
        m.message_end  = closes;
        msg_backlog.insert(msg_backlog.size(), m);
        items_queued++;
    endfunction

    // one message of random bytes with stray no-byte transactions mixed in;
    // the end flag rides on the last byte or comes on its own
    function automatic void queue_message(input int unsigned len);
        msgs_queued++;
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_item(8'($urandom), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(0, 1) == 1)
            begin
                push_item(8'($urandom), 1'b1, 1'b1);
                return;
            end
            push_item(8'($urandom), 1'b1, 1'b0);
        end
        push_item(8'($urandom), 1'b0, 1'b1);
    endfunction

    // mostly short messages, some on the padding boundaries, a few longer
    task automatic random_messages(input int unsigned min_items, input int unsigned min_msgs);
        int unsigned first_item;
        int unsigned first_msg;
        int unsigned sel;
        first_item = items_queued;
        first_msg  = msgs_queued;
        while (items_queued - first_item < min_items || msgs_queued - first_msg < min_msgs)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                queue_message($urandom_range(0, 8));
            else if (sel < 8)
                queue_message(BOUNDARY_LENS[$urandom_range(0, 7)]);
            else
                queue_message($urandom_range(9, 40));
        end
    endtask

    // wait until every transaction went out and every digest word came back
    task automatic drain();
        do
            @(negedge clk);
        while (msg_backlog.size() != 0 || msg_valid || digest_due.size() != 0);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase one: sender idles lightly, receiver stalls heavily
        send_idle_pct = 28;
        recv_idle_pct = 56;

        // empty message
        push_item(8'hA5, 1'b0, 1'b1);
        // stray no-byte transaction, then "abc" closed on its last byte
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        // byte extremes, end flag without a byte and junk in data_byte
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h5A, 1'b0, 1'b1);
        // single-byte messages at both extremes
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        // two empty messages back to back
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hFF, 1'b0, 1'b1);
        msgs_queued += 7;

        random_messages(25, 2);
        drain();

        // phase two: sender idles heavily, receiver stalls lightly
        send_idle_pct = 56;
        recv_idle_pct = 28;
        random_messages(25, 2);
        drain();

        // phase three: full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_messages(25, 2);
        drain();

        // any stray digest word would show up within this window
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("hashed %0d messages from %0d message transactions under three idle mixes",
                 msgs_hashed, items_taken);
        $display("checked %0d digest words, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0)
            $display("sha1_message_digest verification clean");
        else
            $display("sha1_message_digest verification failed");
        $finish;
    end

endmodule

/* sha1_message_digest.f */
sv/sha1md_pkg.sv
sv/sha1_message_digest.sv
sv/sha1md_check.sv
tb/sha1_message_digest_test.sv
